/* sv/bsfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared types and constants for the bounded smallest-factor product block.
// ----------------------------------------------------------------------------
package bsfp_pkg;

    localparam int BSFP_VALUE_WIDTH = 32;

    // operation selected on the shared arithmetic unit
    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

/* sv/bsfp_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_alu
// Shared iterative unit: restoring divide (quotient and remainder) or
// shift-add multiply, one bit per cycle.
// ----------------------------------------------------------------------------
module bsfp_alu import bsfp_pkg::*; #(
    parameter int VALUE_WIDTH = BSFP_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_alu_req               i_req,
    input  logic [VALUE_WIDTH-1:0] i_a,     // dividend or multiplier
    input  logic [VALUE_WIDTH-1:0] i_b,     // divisor or multiplicand
    output logic                   o_done,  // one-cycle pulse, results valid
    output logic [VALUE_WIDTH-1:0] o_quo,   // quotient
    output logic [VALUE_WIDTH-1:0] o_rem    // remainder, or product for MUL
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(VALUE_WIDTH - 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    t_alu_op                r_op, n_op;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_b, n_b;

    logic [VALUE_WIDTH:0]   w_shift;
    logic [VALUE_WIDTH:0]   w_diff;

    assign w_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_b    = r_b;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_quo  = i_a;
            n_rem  = '0;
            n_b    = i_b;
        end else if (r_busy) begin
            case (r_op)
                ALU_DIV: begin
                    if (!w_diff[VALUE_WIDTH]) begin
                        n_rem = w_diff[VALUE_WIDTH-1:0];
                        n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b1};
                    end else begin
                        n_rem = w_shift[VALUE_WIDTH-1:0];
                        n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
                    end
                end
                ALU_MUL: begin
                    // product fits the width by construction; wrap is harmless
                    if (r_quo[0]) begin
                        n_rem = r_rem + r_b;
                    end
                    n_quo = r_quo >> 1;
                    n_b   = r_b << 1;
                end
                default: begin
                    n_rem = r_rem;
                end
            endcase
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

/* sv/bounded_smallest_factor_product.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_smallest_factor_product
// Trial-division factoring; multiplies ascending prime factors into a
// product until the next one would exceed the limit.
// ----------------------------------------------------------------------------
//  channel  | dir | words  | tdata fields (low bit up)
//  s_axis   | in  | 1/item | value, limit
//  m_axis   | out | 1/item | product
//
//  Factors of two are stripped in S_TWO without the unit. Every odd trial
//  divisor costs one pass of the shared divide/multiply unit; each
//  accepted odd factor adds a limit divide, a multiply and one more divide
//  by the same divisor, all on the same unit.
//  Synchronous active-low reset returns the sequencer to idle.
//  Input is taken only when idle; the result holds until m_axis takes it.
// ----------------------------------------------------------------------------
module bounded_smallest_factor_product import bsfp_pkg::*; #(
    parameter int VALUE_WIDTH = BSFP_VALUE_WIDTH,
    localparam int IN_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // value, limit
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // product
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TWO  = 8'b0000_0010,
        S_DIVN = 8'b0000_0100,
        S_DIVL = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_LEFT = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } t_state;

    localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] FIRST_ODD = VALUE_WIDTH'(3);

    t_state                 r_state, n_state;
    logic                   r_wait, n_wait;     // unit operation in flight
    logic                   r_left, n_left;     // leftover-prime path
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [VALUE_WIDTH-1:0] r_lim, n_lim;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [VALUE_WIDTH-1:0] r_d, n_d;

    t_alu_req               w_req;
    logic [VALUE_WIDTH-1:0] w_a;
    logic                   w_done;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [VALUE_WIDTH-1:0] w_rem;

    bsfp_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (r_d),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_left    = r_left;
        n_n       = r_n;
        n_lim     = r_lim;
        n_acc     = r_acc;
        n_d       = r_d;
        w_req     = '{start: 1'b0, op: ALU_DIV};
        w_a       = r_n;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_n     = i_s_axis_tdata[VALUE_WIDTH-1:0];
                    n_lim   = i_s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
                    n_acc   = ONE;
                    n_left  = 1'b0;
                    n_wait  = 1'b0;
                    n_state = S_TWO;
                end
            end
            S_TWO: begin
                if (!r_n[0]) begin
                    if (r_acc > (r_lim >> 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_acc = r_acc << 1;
                        n_n   = r_n >> 1;
                    end
                end else begin
                    n_d     = FIRST_ODD;
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                w_a = r_n;
                if (!r_wait) begin
                    w_req  = '{start: 1'b1, op: ALU_DIV};
                    n_wait = 1'b1;
                end else if (w_done) begin
                    n_wait = 1'b0;
                    if (r_d > w_quo) begin
                        n_state = S_LEFT;
                    end else if (w_rem == '0) begin
                        n_n     = w_quo;
                        n_state = S_DIVL;
                    end else begin
                        n_d = r_d + TWO;
                    end
                end
            end
            S_DIVL: begin
                // factor fits when acc <= lim / d
                w_a = r_lim;
                if (!r_wait) begin
                    w_req  = '{start: 1'b1, op: ALU_DIV};
                    n_wait = 1'b1;
                end else if (w_done) begin
                    n_wait  = 1'b0;
                    n_state = (r_acc > w_quo) ? S_OUT : S_MUL;
                end
            end
            S_MUL: begin
                w_a = r_acc;
                if (!r_wait) begin
                    w_req  = '{start: 1'b1, op: ALU_MUL};
                    n_wait = 1'b1;
                end else if (w_done) begin
                    n_wait  = 1'b0;
                    n_acc   = w_rem;
                    n_state = r_left ? S_OUT : S_DIVN;
                end
            end
            S_LEFT: begin
                // remaining value is odd; anything above one is a prime
                if (r_n == ONE) begin
                    n_state = S_OUT;
                end else begin
                    n_d     = r_n;
                    n_left  = 1'b1;
                    n_state = S_DIVL;
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_left  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_left  <= n_left;
        end
        r_n   <= n_n;
        r_lim <= n_lim;
        r_acc <= n_acc;
        r_d   <= n_d;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = OUT_W'(r_acc);

endmodule

/* verif/bounded_smallest_factor_product_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_smallest_factor_product_tb
// Self-checking bench for the bounded smallest-factor product block. A short
// table of hand-picked words (zero, one, limit extremes, all-ones values,
// early stop at the limit) runs first, then about a hundred random words:
// small values, large values built from small primes, and even noise that
// stops at the first factor. Each product is checked against its table entry
// or a trial-division predictor. Both sides idle at random, and the output
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module bounded_smallest_factor_product_tb import bsfp_pkg::*;;

    localparam int VW          = BSFP_VALUE_WIDTH;
    localparam int IN_W        = ((2 * VW + 7) / 8) * 8;
    localparam int OUT_W       = ((VW + 7) / 8) * 8;
    localparam int NUM_RANDOM  = 100;
    localparam int NUM_DIR     = 22;
    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [VW-1:0] value;
        logic [VW-1:0] limit;
        logic          known;
        logic [VW-1:0] product;
    } t_row;

    typedef struct packed {
        logic [VW-1:0] value;
        logic [VW-1:0] limit;
        logic [VW-1:0] product;
    } t_pending;

    // known products only where they follow at a glance
    localparam t_row DIR_ROWS [NUM_DIR] = '{
        '{32'd1,           32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'd0,           32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
        '{32'd0,           32'd0,         1'b1, 32'd1},
        '{32'd0,           32'd1000,      1'b1, 32'd512},
        '{32'd0,           32'h5555_5555, 1'b1, 32'h4000_0000},
        '{32'hFFFF_FFFF,   32'd0,         1'b1, 32'd1},
        '{32'hFFFF_FFFE,   32'd1,         1'b1, 32'd1},
        '{32'hFFFF_FFFF,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF,   32'hFFFF_FFFE, 1'b1, 32'd65535},
        '{32'h8000_0000,   32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
        '{32'h8000_0000,   32'h7FFF_FFFF, 1'b1, 32'h4000_0000},
        '{32'd97,          32'd96,        1'b1, 32'd1},
        '{32'd97,          32'd97,        1'b1, 32'd97},
        '{32'd9,           32'd8,         1'b1, 32'd3},
        '{32'd4,           32'd3,         1'b1, 32'd2},
        '{32'd3,           32'd2,         1'b1, 32'd1},
        '{32'd25,          32'd25,        1'b1, 32'd25},
        '{32'd360,         32'd100,       1'b0, 32'd0},
        '{32'd1048573,     32'hFFFF_FFFF, 1'b0, 32'd0},
        '{32'd196611,      32'hFFFF_FFFF, 1'b0, 32'd0},
        '{32'h7FFF_FFFE,   32'h0001_0000, 1'b0, 32'd0},
        '{32'hAAAA_AAAA,   32'hFFFF_FFFF, 1'b0, 32'd0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;   // value, limit
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;   // product

    t_pending product_q[$];
    int       words_sent;
    int       results_seen;
    int       mismatches;
    int       stall_cycles;
    int       smooth_words;
    int       noise_words;

    bounded_smallest_factor_product #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Trial division with the exact "acc * f > limit" test done by division.
    function automatic logic [VW-1:0] smallest_factor_product(
        input logic [VW-1:0] value,
        input logic [VW-1:0] limit
    );
        logic [63:0] rem;
        logic [63:0] lim;
        logic [63:0] acc;
        logic [63:0] d;
        rem = 64'(value);
        lim = 64'(limit);
        acc = 64'd1;
        // zero never runs out of twos; the limit ends this loop
        while (rem[0] == 1'b0) begin
            if (acc > lim / 2) return acc[VW-1:0];
            acc = acc * 2;
            rem = rem >> 1;
        end
        for (d = 3; d <= rem / d; d += 2) begin
            while (rem % d == 0) begin
                if (acc > lim / d) return acc[VW-1:0];
                acc = acc * d;
                rem = rem / d;
            end
        end
        if (rem > 2) begin
            if (acc > lim / rem) return acc[VW-1:0];
            acc = acc * rem;
        end
        return acc[VW-1:0];
    endfunction

    // Large value made of small primes, so trial division finishes quickly.
    function automatic logic [VW-1:0] smooth_value();
        int unsigned primes [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [63:0] v;
        int unsigned p;
        v = 64'd1;
        for (int k = 0; k < 40; k++) begin
            p = primes[$urandom_range(0, 11)];
            if (v * p > 64'hFFFF_FFFF) break;
            v = v * p;
            if ($urandom_range(99) < 4) break;
        end
        return v[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] pick_limit(input logic [VW-1:0] value);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return VW'($urandom_range(1, 64));
            2:       return VW'($urandom);
            3:       return '1;
            4:       return value;
            default: return VW'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(
        input logic [VW-1:0] value,
        input logic [VW-1:0] limit,
        input logic          known,
        input logic [VW-1:0] product
    );
        t_pending entry;
        logic     steady;
        steady = (words_sent >= 40) && (words_sent < 70);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 17) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({limit, value});
        do @(posedge i_clk); while (!o_s_axis_tready);
        entry.value   = value;
        entry.limit   = limit;
        entry.product = known ? product : smallest_factor_product(value, limit);
        product_q.insert(product_q.size(), entry);
        words_sent++;
    endtask

    // stimulus and end of run
    initial begin
        logic [VW-1:0] value;
        logic [VW-1:0] limit;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        words_sent      = 0;
        smooth_words    = 0;
        noise_words     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_DIR; r++)
            send_word(DIR_ROWS[r].value, DIR_ROWS[r].limit, DIR_ROWS[r].known,
                      DIR_ROWS[r].product);

        for (int k = 0; k < NUM_RANDOM; k++) begin
            case ($urandom_range(99)) inside
                [0:54]: begin
                    value = VW'($urandom_range(0, 4095));
                    limit = pick_limit(value);
                end
                [55:84]: begin
                    value = smooth_value();
                    limit = pick_limit(value);
                    smooth_words++;
                end
                default: begin
                    // even values with a tiny limit stop at the first two
                    value = VW'($urandom) & ~VW'(1);
                    limit = VW'($urandom_range(0, 1));
                    noise_words++;
                end
            endcase
            send_word(value, limit, 1'b0, '0);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (product_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Covered %0d words (%0d table rows, %0d smooth, %0d even noise), %0d products.",
                 words_sent, NUM_DIR, smooth_words, noise_words, results_seen);
        $display("Output side held off once for %0d cycles; %0d mismatches.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // output side: random idling, one long hold-off that backs up the input
    initial begin
        logic held;
        logic steady;
        held            = 1'b0;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 25) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            steady = (results_seen >= 45) && (results_seen < 75);
            i_m_axis_tready <= steady || ($urandom_range(99) >= 17);
        end
    end

    initial begin
        results_seen = 0;
        mismatches   = 0;
    end

    always @(posedge i_clk) begin
        t_pending entry;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (product_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] product word with nothing pending: %0d",
                             $realtime, o_m_axis_tdata[VW-1:0]);
            end else begin
                entry = product_q.pop_front();
                if (o_m_axis_tdata[VW-1:0] !== entry.product) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] value %0d limit %0d: product exp %0d got %0d",
                                 $realtime, entry.value, entry.limit, entry.product,
                                 o_m_axis_tdata[VW-1:0]);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
